FILE: rtl/vpa_pkg.sv
// Shared types, constants and helpers for the voice pool allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vpa_pkg;

    localparam int MaxVoices   = 1024;
    localparam int MonoDepth   = 512;
    localparam int StereoDepth = 256;
    localparam int AgeBits     = 32;
    localparam int OwnerBits   = 8;
    localparam int PrioBits    = 8;

    localparam int HandleBits    = $clog2(MaxVoices);
    localparam int MonoIdxBits   = $clog2(MonoDepth);
    localparam int StereoIdxBits = $clog2(StereoDepth);
    localparam int MonoCntBits   = MonoIdxBits + 1;
    localparam int StereoCntBits = StereoIdxBits + 1;
    localparam int MonoLimBits   = 10;
    localparam int StereoLimBits = 9;
    localparam int CfgIdxBits    = 1;
    localparam int CfgDataBits   = 10;
    localparam int StatusBits    = 3;

    // Register indexes of the configuration port
    localparam logic [CfgIdxBits-1:0] CfgMonoLimit   = 1'd0;
    localparam logic [CfgIdxBits-1:0] CfgStereoLimit = 1'd1;

    // Operation codes
    localparam logic OpAcquire = 1'b0;
    localparam logic OpRelease = 1'b1;

    // Result status codes
    localparam logic [StatusBits-1:0] StReused   = 3'd0;
    localparam logic [StatusBits-1:0] StCreated  = 3'd1;
    localparam logic [StatusBits-1:0] StStolen   = 3'd2;
    localparam logic [StatusBits-1:0] StNone     = 3'd3;
    localparam logic [StatusBits-1:0] StReleased = 3'd4;
    localparam logic [StatusBits-1:0] StRefused  = 3'd5;

    // Classified command passed from front to back
    typedef struct packed {
        logic                  is_release;
        logic                  is_stereo;
        logic                  handle_ok;
        logic [OwnerBits-1:0]  owner;
        logic [PrioBits-1:0]   prio;
        logic                  loop;
        logic [HandleBits-1:0] handle;
    } cmd_t;

    // One owner table entry
    typedef struct packed {
        logic                 valid;
        logic [OwnerBits-1:0] owner;
        logic [PrioBits-1:0]  prio;
        logic                 loop;
        logic [AgeBits-1:0]   age;
    } entry_t;

    // Mono limit clamped to 8..512
    function automatic logic [MonoLimBits-1:0] eff_mono(input logic [MonoLimBits-1:0] m);
        logic [MonoLimBits-1:0] r;
        r = m;
        if (m > MonoLimBits'(512)) r = MonoLimBits'(512);
        if (m < MonoLimBits'(8))   r = MonoLimBits'(8);
        return r;
    endfunction

    // Stereo limit capped at 256; zero falls back to the mono limit
    function automatic logic [StereoLimBits-1:0] eff_stereo(
        input logic [StereoLimBits-1:0] s,
        input logic [MonoLimBits-1:0]   m
    );
        logic [StereoLimBits-1:0] r;
        logic [MonoLimBits-1:0]   em;
        r  = s;
        em = eff_mono(m);
        if (s > StereoLimBits'(256)) r = StereoLimBits'(256);
        if (s == '0)
        begin
            if (em > MonoLimBits'(256)) r = StereoLimBits'(256);
            else                        r = em[StereoLimBits-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vpa_ifs.sv
// Request and result channel interfaces of the voice pool allocator.
// Depends on vpa_pkg for field widths.
`default_nettype none

interface vpa_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic                           is_stereo;
    logic [vpa_pkg::OwnerBits-1:0]  owner_id;
    logic [vpa_pkg::PrioBits-1:0]   priority_req;
    logic                           looping;
    logic [vpa_pkg::HandleBits-1:0] voice_handle;

    modport source (output valid, opcode, is_stereo, owner_id, priority_req, looping,
                    voice_handle, input ready);
    modport sink   (input valid, opcode, is_stereo, owner_id, priority_req, looping,
                    voice_handle, output ready);
endinterface

interface vpa_out_if;
    logic                           valid;
    logic                           ready;
    logic [vpa_pkg::HandleBits-1:0] granted_handle;
    logic [vpa_pkg::StatusBits-1:0] status;
    logic [vpa_pkg::OwnerBits-1:0]  evicted_owner;

    modport source (output valid, granted_handle, status, evicted_owner, input ready);
    modport sink   (input valid, granted_handle, status, evicted_owner, output ready);
endinterface

`default_nettype wire

FILE: rtl/vpa_front.sv
// Front stage: accepts request beats, classifies them and holds one command.
// Depends on vpa_pkg and vpa_in_if.
`default_nettype none

module vpa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    vpa_in_if.sink             in_ch,
    input  wire logic          clearing,
    output vpa_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);

    logic          valid_reg, valid_next;
    vpa_pkg::cmd_t cmd_reg, cmd_next;
    logic          take;

    // Accept while the hold register is empty or draining, never during the sweep
    assign in_ch.ready = !clearing && (!valid_reg || cmd_ready);
    assign take        = in_ch.valid && in_ch.ready;

    // Classify the beat
    always_comb
    begin
        cmd_next = cmd_reg;
        if (take)
        begin
            cmd_next.is_release = (in_ch.opcode == vpa_pkg::OpRelease);
            cmd_next.is_stereo  = in_ch.is_stereo;
            cmd_next.handle_ok  = (in_ch.voice_handle != '0) &&
                ({1'b0, in_ch.voice_handle} < (vpa_pkg::HandleBits+1)'(vpa_pkg::MaxVoices));
            cmd_next.owner      = in_ch.owner_id;
            cmd_next.prio       = in_ch.priority_req;
            cmd_next.loop       = in_ch.looping;
            cmd_next.handle     = in_ch.voice_handle;
        end
        valid_next = take ? 1'b1 : (cmd_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/vpa_queue.sv
// Two-entry command queue between the front and back stages.
// Depends on vpa_pkg for the command type.
`default_nettype none

module vpa_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  vpa_pkg::cmd_t      push_cmd,
    input  wire logic          push_valid,
    output logic               push_ready,
    output vpa_pkg::cmd_t      pop_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready
);

    vpa_pkg::cmd_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: rtl/vpa_back.sv
// Back stage: owner table, free stacks, counters, steal scan and result register.
// Depends on vpa_pkg and vpa_out_if.
`default_nettype none

module vpa_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  vpa_pkg::cmd_t                         cmd,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire logic [vpa_pkg::MonoLimBits-1:0]  mono_lim,
    input  wire logic [vpa_pkg::StereoLimBits-1:0] stereo_lim,
    output logic                                  clearing,
    vpa_out_if.source                             out_ch
);

    localparam int HB = vpa_pkg::HandleBits;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [HB-1:0] LastHandle = HB'(vpa_pkg::MaxVoices - 1);

    logic [2:0] st_reg, st_next;
    logic [HB-1:0] clr_idx_reg, clr_idx_next;
    vpa_pkg::cmd_t cur_reg, cur_next;

    logic [vpa_pkg::MonoCntBits-1:0]   mono_cnt_reg, mono_cnt_next;
    logic [vpa_pkg::StereoCntBits-1:0] stereo_cnt_reg, stereo_cnt_next;
    logic [vpa_pkg::MonoLimBits-1:0]   mono_made_reg, mono_made_next;
    logic [vpa_pkg::StereoLimBits-1:0] stereo_made_reg, stereo_made_next;
    logic [vpa_pkg::AgeBits-1:0]       age_reg, age_next;
    logic [HB:0]                       next_h_reg, next_h_next;

    // Scan bookkeeping
    logic [HB-1:0] scan_addr_reg, scan_addr_next;
    logic          issue_done_reg, issue_done_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [HB-1:0] rd_h_reg, rd_h_next;
    logic          best_found_reg, best_found_next;
    logic [vpa_pkg::PrioBits-1:0]  best_p_reg, best_p_next;
    logic [vpa_pkg::AgeBits-1:0]   best_a_reg, best_a_next;
    logic [HB-1:0]                 best_h_reg, best_h_next;
    logic [vpa_pkg::OwnerBits-1:0] best_o_reg, best_o_next;

    // Result register
    logic                           out_valid_reg, out_valid_next;
    logic [HB-1:0]                  out_h_reg, out_h_next;
    logic [vpa_pkg::StatusBits-1:0] out_st_reg, out_st_next;
    logic [vpa_pkg::OwnerBits-1:0]  out_ev_reg, out_ev_next;

    // Memories
    vpa_pkg::entry_t tbl_mem [vpa_pkg::MaxVoices];
    logic [HB-1:0] mono_mem   [vpa_pkg::MonoDepth];
    logic [HB-1:0] stereo_mem [vpa_pkg::StereoDepth];
    vpa_pkg::entry_t tbl_rd_reg;
    logic [HB-1:0]   mono_rd_reg, stereo_rd_reg;

    logic            tw_en;
    logic [HB-1:0]   tw_addr;
    vpa_pkg::entry_t tw_data;
    logic [HB-1:0]   tr_addr;
    logic                            mw_en, sw_en;
    logic [vpa_pkg::MonoIdxBits-1:0]   mw_addr, mr_addr;
    logic [vpa_pkg::StereoIdxBits-1:0] sw_addr, sr_addr;

    logic [vpa_pkg::MonoCntBits-1:0]   mono_dec;
    logic [vpa_pkg::StereoCntBits-1:0] stereo_dec;
    logic [vpa_pkg::AgeBits-1:0]       age_inc;
    logic [vpa_pkg::MonoLimBits-1:0]   mono_eff;
    logic [vpa_pkg::StereoLimBits-1:0] stereo_eff;
    logic [HB-1:0] pop_h;
    logic          take, stack_full, stack_has, can_make, better;

    assign clearing  = (st_reg == S_CLEAR);
    assign take      = (st_reg == S_IDLE) && cmd_valid && !out_valid_reg;
    assign cmd_ready = take;

    assign mono_dec   = mono_cnt_reg - vpa_pkg::MonoCntBits'(1);
    assign stereo_dec = stereo_cnt_reg - vpa_pkg::StereoCntBits'(1);
    assign age_inc    = (age_reg != '1) ? age_reg + vpa_pkg::AgeBits'(1) : age_reg;
    assign mono_eff   = vpa_pkg::eff_mono(mono_lim);
    assign stereo_eff = vpa_pkg::eff_stereo(stereo_lim, mono_lim);
    assign pop_h      = cur_reg.is_stereo ? stereo_rd_reg : mono_rd_reg;

    assign stack_full = cmd.is_stereo
        ? (stereo_cnt_reg >= vpa_pkg::StereoCntBits'(vpa_pkg::StereoDepth))
        : (mono_cnt_reg >= vpa_pkg::MonoCntBits'(vpa_pkg::MonoDepth));
    assign stack_has = cmd.is_stereo ? (stereo_cnt_reg != '0) : (mono_cnt_reg != '0);
    assign can_make  = (next_h_reg < (HB+1)'(vpa_pkg::MaxVoices)) &&
        (cmd.is_stereo ? (stereo_made_reg < stereo_eff) : (mono_made_reg < mono_eff));

    // Steal candidate: live, not looping, lower priority or older on a tie
    assign better = tbl_rd_reg.valid && !tbl_rd_reg.loop &&
        (!best_found_reg || (tbl_rd_reg.prio < best_p_reg) ||
         ((tbl_rd_reg.prio == best_p_reg) && (tbl_rd_reg.age < best_a_reg)));

    always_comb
    begin
        st_next          = st_reg;
        clr_idx_next     = clr_idx_reg;
        cur_next         = cur_reg;
        mono_cnt_next    = mono_cnt_reg;
        stereo_cnt_next  = stereo_cnt_reg;
        mono_made_next   = mono_made_reg;
        stereo_made_next = stereo_made_reg;
        age_next         = age_reg;
        next_h_next      = next_h_reg;
        scan_addr_next   = scan_addr_reg;
        issue_done_next  = issue_done_reg;
        rd_pend_next     = 1'b0;
        rd_h_next        = rd_h_reg;
        best_found_next  = best_found_reg;
        best_p_next      = best_p_reg;
        best_a_next      = best_a_reg;
        best_h_next      = best_h_reg;
        best_o_next      = best_o_reg;
        out_valid_next   = (out_valid_reg && out_ch.ready) ? 1'b0 : out_valid_reg;
        out_h_next       = out_h_reg;
        out_st_next      = out_st_reg;
        out_ev_next      = out_ev_reg;
        tw_en    = 1'b0;
        tw_addr  = clr_idx_reg;
        tw_data  = '0;
        tr_addr  = scan_addr_reg;
        mw_en    = 1'b0;
        sw_en    = 1'b0;
        mw_addr  = mono_cnt_reg[vpa_pkg::MonoIdxBits-1:0];
        sw_addr  = stereo_cnt_reg[vpa_pkg::StereoIdxBits-1:0];
        mr_addr  = mono_dec[vpa_pkg::MonoIdxBits-1:0];
        sr_addr  = stereo_dec[vpa_pkg::StereoIdxBits-1:0];

        case (st_reg)
            // Sweep the owner table to invalid after reset
            S_CLEAR:
            begin
                tw_en = 1'b1;
                if (clr_idx_reg == LastHandle)
                    st_next = S_IDLE;
                else
                    clr_idx_next = clr_idx_reg + HB'(1);
            end
            S_IDLE:
            begin
                if (take)
                begin
                    cur_next    = cmd;
                    out_ev_next = '0;
                    out_h_next  = '0;
                    if (cmd.is_release)
                    begin
                        out_valid_next = 1'b1;
                        if (!cmd.handle_ok || stack_full)
                            out_st_next = vpa_pkg::StRefused;
                        else
                        begin
                            // Clear the entry and push the handle
                            out_st_next = vpa_pkg::StReleased;
                            tw_en   = 1'b1;
                            tw_addr = cmd.handle;
                            if (cmd.is_stereo)
                            begin
                                sw_en           = 1'b1;
                                stereo_cnt_next = stereo_cnt_reg + vpa_pkg::StereoCntBits'(1);
                            end
                            else
                            begin
                                mw_en         = 1'b1;
                                mono_cnt_next = mono_cnt_reg + vpa_pkg::MonoCntBits'(1);
                            end
                        end
                    end
                    else if (stack_has)
                    begin
                        // Pop: data arrives next cycle
                        if (cmd.is_stereo) stereo_cnt_next = stereo_dec;
                        else               mono_cnt_next   = mono_dec;
                        st_next = S_POP;
                    end
                    else if (can_make)
                    begin
                        out_valid_next = 1'b1;
                        out_st_next    = vpa_pkg::StCreated;
                        out_h_next     = next_h_reg[HB-1:0];
                        next_h_next    = next_h_reg + (HB+1)'(1);
                        if (cmd.is_stereo)
                            stereo_made_next = stereo_made_reg + vpa_pkg::StereoLimBits'(1);
                        else
                            mono_made_next = mono_made_reg + vpa_pkg::MonoLimBits'(1);
                        age_next = age_inc;
                        tw_en    = 1'b1;
                        tw_addr  = next_h_reg[HB-1:0];
                        tw_data  = '{valid: 1'b1, owner: cmd.owner, prio: cmd.prio,
                                     loop: cmd.loop, age: age_inc};
                    end
                    else
                    begin
                        scan_addr_next  = HB'(1);
                        issue_done_next = 1'b0;
                        best_found_next = 1'b0;
                        st_next         = S_SCAN;
                    end
                end
            end
            S_POP:
            begin
                out_valid_next = 1'b1;
                out_st_next    = vpa_pkg::StReused;
                out_h_next     = pop_h;
                age_next       = age_inc;
                tw_en          = 1'b1;
                tw_addr        = pop_h;
                tw_data        = '{valid: 1'b1, owner: cur_reg.owner, prio: cur_reg.prio,
                                   loop: cur_reg.loop, age: age_inc};
                st_next        = S_IDLE;
            end
            // Walk handles one per cycle, keep the best victim
            S_SCAN:
            begin
                if (rd_pend_reg && better)
                begin
                    best_found_next = 1'b1;
                    best_p_next     = tbl_rd_reg.prio;
                    best_a_next     = tbl_rd_reg.age;
                    best_h_next     = rd_h_reg;
                    best_o_next     = tbl_rd_reg.owner;
                end
                if (!issue_done_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_h_next    = scan_addr_reg;
                    if (scan_addr_reg == LastHandle)
                        issue_done_next = 1'b1;
                    else
                        scan_addr_next = scan_addr_reg + HB'(1);
                end
                else if (!rd_pend_reg)
                    st_next = S_FIN;
            end
            S_FIN:
            begin
                out_valid_next = 1'b1;
                st_next        = S_IDLE;
                if (best_found_reg)
                begin
                    out_st_next = vpa_pkg::StStolen;
                    out_h_next  = best_h_reg;
                    out_ev_next = best_o_reg;
                    age_next    = age_inc;
                    tw_en       = 1'b1;
                    tw_addr     = best_h_reg;
                    tw_data     = '{valid: 1'b1, owner: cur_reg.owner, prio: cur_reg.prio,
                                    loop: cur_reg.loop, age: age_inc};
                end
                else
                    out_st_next = vpa_pkg::StNone;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= S_CLEAR;
            clr_idx_reg     <= '0;
            mono_cnt_reg    <= '0;
            stereo_cnt_reg  <= '0;
            mono_made_reg   <= '0;
            stereo_made_reg <= '0;
            age_reg         <= '0;
            next_h_reg      <= (HB+1)'(1);
            issue_done_reg  <= 1'b0;
            rd_pend_reg     <= 1'b0;
            best_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg          <= st_next;
            clr_idx_reg     <= clr_idx_next;
            mono_cnt_reg    <= mono_cnt_next;
            stereo_cnt_reg  <= stereo_cnt_next;
            mono_made_reg   <= mono_made_next;
            stereo_made_reg <= stereo_made_next;
            age_reg         <= age_next;
            next_h_reg      <= next_h_next;
            issue_done_reg  <= issue_done_next;
            rd_pend_reg     <= rd_pend_next;
            best_found_reg  <= best_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        scan_addr_reg <= scan_addr_next;
        rd_h_reg      <= rd_h_next;
        best_p_reg    <= best_p_next;
        best_a_reg    <= best_a_next;
        best_h_reg    <= best_h_next;
        best_o_reg    <= best_o_next;
        out_h_reg     <= out_h_next;
        out_st_reg    <= out_st_next;
        out_ev_reg    <= out_ev_next;
    end

    // Owner table: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (tw_en)
            tbl_mem[tw_addr] <= tw_data;
        tbl_rd_reg <= tbl_mem[tr_addr];
    end

    // Free stacks
    always_ff @(posedge clk)
    begin
        if (mw_en)
            mono_mem[mw_addr] <= cmd.handle;
        mono_rd_reg <= mono_mem[mr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
            stereo_mem[sw_addr] <= cmd.handle;
        stereo_rd_reg <= stereo_mem[sr_addr];
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.granted_handle = out_h_reg;
    assign out_ch.status         = out_st_reg;
    assign out_ch.evicted_owner  = out_ev_reg;

    a_mono_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        mono_cnt_reg <= vpa_pkg::MonoCntBits'(vpa_pkg::MonoDepth))
        else $error("mono free count above stack depth");

    a_stereo_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        stereo_cnt_reg <= vpa_pkg::StereoCntBits'(vpa_pkg::StereoDepth))
        else $error("stereo free count above stack depth");

    a_next_h: assert property (@(posedge clk) disable iff (!rst_n)
        next_h_reg != '0)
        else $error("next handle reached zero");

    a_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_FIN && best_found_reg) |-> best_h_reg != '0)
        else $error("steal victim is the null handle");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_POP || st_reg == S_FIN) |-> !out_valid_reg)
        else $error("result produced over a pending one");

endmodule

`default_nettype wire

FILE: rtl/voice_pool_allocator_with_stealing_core.sv
// Top level of the voice pool allocator: configuration registers, front, queue, back.
// Depends on vpa_pkg, vpa_ifs, vpa_front, vpa_queue and vpa_back.
//
//  Channel   Dir  Beat contents
//  in_ch     in   opcode, is_stereo, owner_id, priority_req, looping, voice_handle
//  out_ch    out  granted_handle, status, evicted_owner
//  cfg       in   cfg_we, cfg_index, cfg_data (0 mono_limit, 1 stereo_limit)
//
// Release, create and refuse set the result register when taken; reuse first reads
// the free stack, then S_POP; a steal or a failed steal walks the owner table one
// handle per cycle, then S_FIN. After reset the owner table is swept to invalid;
// in_ch is not ready during the sweep. A command register and a two-entry queue
// let requests be accepted while a result waits on out_ch.
`default_nettype none

module voice_pool_allocator_with_stealing_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    vpa_in_if.sink                                  in_ch,
    vpa_out_if.source                               out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [vpa_pkg::CfgIdxBits-1:0]     cfg_index,
    input  wire logic [vpa_pkg::CfgDataBits-1:0]    cfg_data
);

    logic [vpa_pkg::MonoLimBits-1:0]   mono_lim_reg, mono_lim_next;
    logic [vpa_pkg::StereoLimBits-1:0] stereo_lim_reg, stereo_lim_next;
    vpa_pkg::cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready, clearing;

    // Write configuration registers
    always_comb
    begin
        mono_lim_next   = mono_lim_reg;
        stereo_lim_next = stereo_lim_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vpa_pkg::CfgMonoLimit:   mono_lim_next   = cfg_data[vpa_pkg::MonoLimBits-1:0];
                vpa_pkg::CfgStereoLimit: stereo_lim_next = cfg_data[vpa_pkg::StereoLimBits-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_lim_reg   <= vpa_pkg::MonoLimBits'(256);
            stereo_lim_reg <= vpa_pkg::StereoLimBits'(256);
        end
        else
        begin
            mono_lim_reg   <= mono_lim_next;
            stereo_lim_reg <= stereo_lim_next;
        end
    end

    vpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .clearing  (clearing),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready)
    );

    vpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (f_cmd),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_cmd    (q_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    vpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (q_cmd),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .mono_lim   (mono_lim_reg),
        .stereo_lim (stereo_lim_reg),
        .clearing   (clearing),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
